// ===== design/gws_pkg.sv =====
// Shared types, operation codes and the distance function for the grid window block.
package gws_pkg;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_SUM   = 3'd2;
    localparam logic [2:0] OP_ADD   = 3'd3;
    localparam logic [2:0] OP_SUB   = 3'd4;
    localparam logic [2:0] OP_MUL   = 3'd5;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int DistMax = 10;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] col;
        logic [6:0] row;
        logic [2:0] rad;
        logic [7:0] val;
        logic [6:0] w;
        logic [6:0] h;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] window_total;
        logic        status;
    } res_t;

    function automatic logic [3:0] ceil_dist(input logic [2:0] dx, input logic [2:0] dy);
        logic [6:0] s;
        logic [3:0] d;
        s = 7'({4'd0, dx} * {4'd0, dx}) + 7'({4'd0, dy} * {4'd0, dy});
        d = 4'd0;
        for (int k = 1; k <= DistMax; k++)
        begin
            if (7'((k - 1) * (k - 1)) < s)
            begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

// ===== design/grid_window_sum_and_radial_stamp.sv =====
// Top level: grid of 8-bit cells with window sum and radial stamp requests.
//
// One request beat enters on s_*; one result beat leaves on m_* for each request.
// s_tuser carries the operation; s_tdata carries col, row, radius and cell_value.
// m_tdata carries read_data and window_total; m_tuser carries status.
// Grid size registers are written on cfg_we / cfg_index / cfg_data; the user is to
// write them only while idle, which the block itself does not enforce. A request
// sweeps (2r+1)^2 cells, r the clamped radius (zero for read and write), one
// read-modify-write per cycle through the single cell memory port pair.
// A sweep's result passes S_DRAIN and S_DONE into the output register; the next
// request waits for S_IDLE. An invalid centre or unknown operation skips to S_DONE.
// After reset the memory is cleared one cell per cycle, all MAX_WIDTH*MAX_HEIGHT
// cells (4096 by default), with s_tready low; config writes are taken meanwhile.
// A finished result sits in the output register while m_tready is low, and a
// second finished result waits in the sequencer, holding s_tready low.
module grid_window_sum_and_radial_stamp
    import gws_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // col[6:0], row[13:7], radius[16:14], cell_value[24:17]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data[7:0], window_total[23:8]
    output logic [0:0]  m_tuser,   // status[0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [6:0]    width_reg, height_reg;
    logic [6:0]    w_eff, h_eff;
    logic [2:0]    radius;
    logic [2:0]    rad_eff;
    req_t          req;
    logic          start, ready, res_valid, res_take;
    res_t          res;
    logic          out_valid_reg;
    res_t          out_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < 7'd3)
        begin
            w_eff = 7'd3;
        end
        else if ({2'd0, width_reg} > 9'(MAX_WIDTH))
        begin
            w_eff = 7'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg < 7'd3)
        begin
            h_eff = 7'd3;
        end
        else if ({2'd0, height_reg} > 9'(MAX_HEIGHT))
        begin
            h_eff = 7'(MAX_HEIGHT);
        end
    end

    assign radius  = s_tdata[16:14];
    assign rad_eff = ({1'b0, radius} > 4'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius;

    assign req.op  = s_tuser;
    assign req.col = s_tdata[6:0];
    assign req.row = s_tdata[13:7];
    assign req.rad = rad_eff;
    assign req.val = s_tdata[24:17];
    assign req.w   = w_eff;
    assign req.h   = h_eff;

    assign s_tready = ready;
    assign start    = s_tvalid && ready;
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    gws_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .DEPTH     (DEPTH),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .ready     (ready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    gws_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.window_total, out_reg.read_data};
    assign m_tuser  = out_reg.status;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a request is in progress");

    a_result_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready)
        else $error("input open while a result is pending");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid_reg && !m_tready |=> res_valid)
        else $error("pending result lost while output stalled");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !s_tready)
        else $error("cell memory written while idle");

endmodule

// ===== design/gws_store.sv =====
// Cell memory: one write port and one registered read port.
module gws_store
    import gws_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gws_ctrl.sv =====
// Sequencer: clearing pass, window scan and read-modify-write of the cell memory.
module gws_ctrl
    import gws_pkg::*;
#(
    parameter int MAX_WIDTH = 64,
    parameter int DEPTH     = 4096,
    parameter int AW        = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  req_t          req,
    output logic          ready,
    output logic          res_valid,
    output res_t          res,
    input  logic          res_take,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    req_t          req_reg, req_next;
    logic [3:0]    ro_reg, ro_next;
    logic [3:0]    co_reg, co_next;
    logic          p1_valid_reg, p1_valid_next;
    logic [AW-1:0] p1_addr_reg, p1_addr_next;
    logic [7:0]    p1_fall_reg, p1_fall_next;
    logic [15:0]   acc_reg, acc_next;
    logic [7:0]    rd_reg, rd_next;
    logic          status_reg, status_next;

    logic          single;
    logic [3:0]    span;
    logic [7:0]    rr, cc, rpos, cpos;
    logic          row_in, col_in, cell_ok;
    logic [2:0]    dx, dy;
    logic [3:0]    dist_val;
    logic [16:0]   sum17;

    assign single = (req_reg.op == OP_READ) || (req_reg.op == OP_WRITE);
    assign span   = {req_reg.rad, 1'b0};
    assign rr     = {1'b0, req_reg.row} + {4'd0, ro_reg};
    assign cc     = {1'b0, req_reg.col} + {4'd0, co_reg};
    assign rpos   = rr - {5'd0, req_reg.rad};
    assign cpos   = cc - {5'd0, req_reg.rad};
    assign row_in = (rr >= {5'd0, req_reg.rad} + 8'd1)
                 && (rr <= {1'b0, req_reg.h} - 8'd2 + {5'd0, req_reg.rad});
    assign col_in = (cc >= {5'd0, req_reg.rad} + 8'd1)
                 && (cc <= {1'b0, req_reg.w} - 8'd2 + {5'd0, req_reg.rad});
    assign cell_ok = single || (row_in && col_in);
    assign dx     = (co_reg > {1'b0, req_reg.rad}) ? 3'(co_reg - {1'b0, req_reg.rad})
                                                   : 3'({1'b0, req_reg.rad} - co_reg);
    assign dy     = (ro_reg > {1'b0, req_reg.rad}) ? 3'(ro_reg - {1'b0, req_reg.rad})
                                                   : 3'({1'b0, req_reg.rad} - ro_reg);
    assign dist_val = ceil_dist(dx, dy);
    assign sum17  = {1'b0, acc_reg} + {9'd0, mem_rdata};

    assign mem_raddr = AW'(32'(rpos) * MAX_WIDTH + 32'(cpos));

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        req_next      = req_reg;
        ro_next       = ro_reg;
        co_next       = co_reg;
        p1_valid_next = 1'b0;
        p1_addr_next  = mem_raddr;
        p1_fall_next  = (req_reg.val > {4'd0, dist_val}) ? req_reg.val - {4'd0, dist_val}
                                                         : 8'd0;
        acc_next      = acc_reg;
        rd_next       = rd_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = p1_addr_reg;
        mem_wdata     = mem_rdata;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'd0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req;
                    ro_next     = 4'd0;
                    co_next     = 4'd0;
                    acc_next    = 16'd0;
                    rd_next     = 8'd0;
                    status_next = 1'b0;
                    if ((req.op == OP_READ) || (req.op == OP_WRITE))
                    begin
                        req_next.rad = 3'd0;
                    end
                    if (req.op > OP_MUL)
                    begin
                        state_next = S_DONE;
                    end
                    else if ((req.col >= req.w) || (req.row >= req.h))
                    begin
                        status_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                p1_valid_next = cell_ok;
                if (co_reg == span)
                begin
                    co_next = 4'd0;
                    if (ro_reg == span)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        ro_next = ro_reg + 4'd1;
                    end
                end
                else
                begin
                    co_next = co_reg + 4'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (p1_valid_reg)
        begin
            case (req_reg.op)
                OP_READ:
                begin
                    rd_next = mem_rdata;
                end
                OP_WRITE:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = req_reg.val;
                end
                OP_SUM:
                begin
                    acc_next = sum17[16] ? 16'hFFFF : sum17[15:0];
                end
                OP_ADD:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata + p1_fall_reg;
                end
                OP_SUB:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata - p1_fall_reg;
                end
                OP_MUL:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = 8'({8'd0, mem_rdata} * {8'd0, p1_fall_reg});
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        ro_reg      <= ro_next;
        co_reg      <= co_next;
        p1_addr_reg <= p1_addr_next;
        p1_fall_reg <= p1_fall_next;
        acc_reg     <= acc_next;
        rd_reg      <= rd_next;
        status_reg  <= status_next;
    end

    assign ready               = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_DONE);
    assign res.read_data       = rd_reg;
    assign res.window_total    = acc_reg;
    assign res.status          = status_reg;

endmodule

// ===== tb/tb_grid_window_sum_and_radial_stamp.sv =====
`timescale 1ns / 1ps
// Testbench for the grid window sum and radial stamp block: requests checked against a cell model.
module tb_grid_window_sum_and_radial_stamp;
    import gws_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int GRID_MAX_W = 64;
    localparam int GRID_MAX_H = 64;
    localparam int RAD_MAX = 7;
    localparam int HOLD_CYCLES = 800;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 72;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] col;
        logic [6:0] row;
        logic [2:0] rad;
        logic [7:0] val;
    } grid_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // col[6:0], row[13:7], radius[16:14], cell_value[24:17]
    logic [2:0]  s_tuser = '0;   // operation[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // read_data[7:0], window_total[23:8]
    logic [0:0]  m_tuser;        // status[0]
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_WIDTH;
    logic [6:0]  cfg_data = '0;

    logic [7:0] cell_model [GRID_MAX_W * GRID_MAX_H];
    logic [6:0] grid_w = 7'd64;
    logic [6:0] grid_h = 7'd64;
    grid_req_t  req_q [$];
    res_t       result_q [$];
    grid_req_t  held_req;
    grid_req_t  next_req;
    int         burst_left = 0;
    int         gap_left = 0;
    int         rx_tick = 0;
    logic       rx_ready;
    res_t       got_res;
    res_t       want_res;
    int         mismatch_n = 0;
    int         hold_cnt = 0;
    logic       hold_go = 1'b0;
    logic       hold_used = 1'b0;

    grid_window_sum_and_radial_stamp #(
        .MAX_WIDTH  (GRID_MAX_W),
        .MAX_HEIGHT (GRID_MAX_H),
        .MAX_RADIUS (RAD_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_size(input logic [6:0] v, input int lim);
        if (v < 7'd3)
            return 3;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic res_t grid_apply(input grid_req_t q);
        res_t r;
        int w;
        int h;
        int rad;
        int idx;
        int dx;
        int dy;
        int d;
        int f;
        int total;
        r = '0;
        total = 0;
        w = eff_size(grid_w, GRID_MAX_W);
        h = eff_size(grid_h, GRID_MAX_H);
        rad = (int'(q.rad) > RAD_MAX) ? RAD_MAX : int'(q.rad);
        if (q.op > OP_MUL)
            return r;
        if (int'(q.col) >= w || int'(q.row) >= h)
        begin
            r.status = 1'b1;
            return r;
        end
        idx = int'(q.row) * GRID_MAX_W + int'(q.col);
        case (q.op)
            OP_READ:
                r.read_data = cell_model[idx];
            OP_WRITE:
                cell_model[idx] = q.val;
            default:
            begin
                for (int rr = int'(q.row) - rad; rr <= int'(q.row) + rad; rr++)
                begin
                    for (int cc = int'(q.col) - rad; cc <= int'(q.col) + rad; cc++)
                    begin
                        if (rr >= 1 && rr <= h - 2 && cc >= 1 && cc <= w - 2)
                        begin
                            idx = rr * GRID_MAX_W + cc;
                            if (q.op == OP_SUM)
                            begin
                                total = total + int'(cell_model[idx]);
                                if (total > 65535)
                                    total = 65535;
                            end
                            else
                            begin
                                dx = (cc > int'(q.col)) ? cc - int'(q.col) : int'(q.col) - cc;
                                dy = (rr > int'(q.row)) ? rr - int'(q.row) : int'(q.row) - rr;
                                d = 0;
                                while (d * d < dx * dx + dy * dy)
                                    d++;
                                f = (int'(q.val) > d) ? int'(q.val) - d : 0;
                                case (q.op)
                                    OP_ADD:  cell_model[idx] = 8'(int'(cell_model[idx]) + f);
                                    OP_SUB:  cell_model[idx] = 8'(int'(cell_model[idx]) - f);
                                    default: cell_model[idx] = 8'(int'(cell_model[idx]) * f);
                                endcase
                            end
                        end
                    end
                end
            end
        endcase
        r.window_total = 16'(total);
        return r;
    endfunction

    function automatic grid_req_t mk(input logic [2:0] op, input int col, input int row,
                                     input int rad, input int val);
        grid_req_t q;
        q.op = op;
        q.col = 7'(col);
        q.row = 7'(row);
        q.rad = 3'(rad);
        q.val = 8'(val);
        return q;
    endfunction

    function automatic logic [6:0] rand_coord(input int n);
        case ($urandom_range(0, 15))
            0:       return 7'd0;
            1:       return 7'(n - 1);
            2:       return 7'(n);
            3:       return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(0, n - 1));
        endcase
    endfunction

    function automatic grid_req_t rand_req();
        grid_req_t q;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            q.op = OP_READ;
        else if (pick < 7)
            q.op = OP_WRITE;
        else if (pick < 11)
            q.op = OP_SUM;
        else if (pick < 14)
            q.op = OP_ADD;
        else if (pick < 16)
            q.op = OP_SUB;
        else if (pick < 19)
            q.op = OP_MUL;
        else
            q.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_B));
        q.col = rand_coord(eff_size(grid_w, GRID_MAX_W));
        q.row = rand_coord(eff_size(grid_h, GRID_MAX_H));
        if ($urandom_range(0, 2) != 0)
            q.rad = 3'($urandom_range(0, 3));
        else
            q.rad = 3'($urandom_range(4, RAD_MAX));
        q.val = 8'($urandom_range(0, 255));
        return q;
    endfunction

    task automatic put_reg(input logic idx, input logic [6:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            grid_w = data;
        else
            grid_h = data;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_q.size() != 0 || s_tvalid || result_q.size() != 0);
    endtask

    task automatic run_phase(input logic [6:0] w, input logic [6:0] h, input logic with_hold);
        put_reg(CFG_WIDTH, w);
        put_reg(CFG_HEIGHT, h);
        @(negedge clk);
        repeat (RANDOM_PER_PHASE)
            req_q.push_back(rand_req());
        if (with_hold)
            hold_go = 1'b1;
        wait_idle();
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                result_q.push_back(grid_apply(held_req));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    next_req = req_q.pop_front();
                    held_req = next_req;
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, next_req.val, next_req.rad, next_req.row, next_req.col};
                    s_tuser <= next_req.op;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 6);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_cnt <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_res = {m_tdata[7:0], m_tdata[23:8], m_tuser[0]};
                if (result_q.size() == 0)
                begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("unexpected beat: read_data=%0d window_total=%0d status=%0d",
                                 got_res.read_data, got_res.window_total, got_res.status);
                end
                else
                begin
                    want_res = result_q.pop_front();
                    if (got_res !== want_res)
                    begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want_res.read_data, want_res.window_total,
                                     want_res.status, got_res.read_data,
                                     got_res.window_total, got_res.status);
                    end
                end
            end
            rx_tick++;
            case (rx_tick[9:8])
                2'd0:    rx_ready = 1'b1;
                2'd1:    rx_ready = ($urandom_range(0, 3) != 0);
                2'd2:    rx_ready = ($urandom_range(0, 1) == 1);
                default: rx_ready = (rx_tick[4:0] < 5'd4);
            endcase
            m_tready <= rx_ready && (hold_cnt == 0);
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        foreach (cell_model[i])
            cell_model[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        put_reg(CFG_WIDTH, 7'd64);
        put_reg(CFG_HEIGHT, 7'd64);
        @(negedge clk);
        req_q.push_back(mk(OP_WRITE, 0, 0, 7, 255));
        req_q.push_back(mk(OP_READ, 0, 0, 0, 0));
        req_q.push_back(mk(OP_WRITE, 63, 63, 0, 8'h80));
        req_q.push_back(mk(OP_READ, 63, 63, 5, 0));
        req_q.push_back(mk(OP_WRITE, 5, 5, 0, 8'h7F));
        req_q.push_back(mk(OP_READ, 64, 0, 0, 0));
        req_q.push_back(mk(OP_READ, 0, 64, 0, 0));
        req_q.push_back(mk(OP_SUM, 127, 127, 7, 0));
        req_q.push_back(mk(OP_ADD, 100, 3, 2, 50));
        req_q.push_back(mk(OP_SPARE_A, 1, 1, 1, 10));
        req_q.push_back(mk(OP_SPARE_B, 127, 127, 7, 255));
        req_q.push_back(mk(OP_SUM, 5, 5, 0, 0));
        req_q.push_back(mk(OP_ADD, 10, 10, 7, 255));
        req_q.push_back(mk(OP_SUM, 10, 10, 7, 0));
        req_q.push_back(mk(OP_SUB, 12, 9, 3, 200));
        req_q.push_back(mk(OP_MUL, 10, 10, 2, 3));
        req_q.push_back(mk(OP_SUM, 10, 10, 7, 0));
        req_q.push_back(mk(OP_ADD, 0, 0, 4, 9));
        req_q.push_back(mk(OP_SUM, 1, 1, 7, 0));
        req_q.push_back(mk(OP_ADD, 63, 63, 5, 1));
        req_q.push_back(mk(OP_SUM, 62, 62, 7, 0));
        req_q.push_back(mk(OP_READ, 11, 10, 0, 0));
        req_q.push_back(mk(OP_SUB, 60, 2, 6, 255));
        req_q.push_back(mk(OP_SUM, 60, 2, 6, 0));
        req_q.push_back(mk(OP_WRITE, 62, 62, 3, 0));
        wait_idle();
        run_phase(7'd0, 7'd127, 1'b0);
        run_phase(7'd9, 7'd5, 1'b0);
        run_phase(7'd127, 7'd2, 1'b0);
        run_phase(7'd40, 7'd17, 1'b1);
        run_phase(7'd3, 7'd3, 1'b0);
        run_phase(7'd2, 7'd64, 1'b0);
        run_phase(7'd64, 7'd64, 1'b0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_n == 0 && result_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
